@@ rtl/core/plob_pkg.sv @@
// ----------------------------------------------------------------------------
// Price level order book package
// Shared codes, constants and command types of the order book.
// ----------------------------------------------------------------------------
package plob_pkg;

    localparam int LEVELS_DEF     = 32;
    localparam int PRICE_BITS_DEF = 32;
    localparam int SIZE_BITS_DEF  = 32;

    localparam int ORD_BITS     = 16;
    localparam int TS_BITS      = 63;
    localparam int THR_BITS     = 40;
    localparam int DEPTH_BITS   = 6;
    localparam int POS_BITS     = 8;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [THR_BITS-1:0]   STALE_RESET = 40'd3000000000;
    localparam logic [DEPTH_BITS-1:0] DEPTH_RESET = 6'd1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_DEPTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STRICT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STALE  = 2'd2;

    typedef enum logic [1:0] {
        KIND_LEVEL,
        KIND_ORDER,
        KIND_SNAP,
        KIND_HEARTBEAT
    } t_kind;

    typedef enum logic [1:0] {
        ACT_ADD,
        ACT_MODIFY,
        ACT_CANCEL,
        ACT_TRADE
    } t_action;

    typedef enum logic [2:0] {
        C_HOLD,
        C_LOAD,
        C_SIZE,
        C_SIZE_ORD,
        C_FROM_PREV,
        C_FROM_NEXT
    } t_cell_op;

    typedef enum logic [2:0] {
        LAD_IDLE,
        LAD_INSERT,
        LAD_ERASE,
        LAD_LOAD,
        LAD_SIZE,
        LAD_SIZE_ORD
    } t_lad_op;

    typedef struct packed {
        t_lad_op               op;
        logic [POS_BITS-1:0]   pos;
    } t_lad_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_APPLY,
        S_TRADE,
        S_EVAL
    } t_state;

endpackage

@@ rtl/core/plob_in_if.sv @@
// ----------------------------------------------------------------------------
// Order book input channel
// Valid/ready channel that carries one feed message per beat.
// ----------------------------------------------------------------------------
interface plob_in_if #(
    parameter int PRICE_BITS = plob_pkg::PRICE_BITS_DEF,
    parameter int SIZE_BITS  = plob_pkg::SIZE_BITS_DEF
);
    import plob_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            kind;
    logic                  side;
    logic [1:0]            action;
    logic [PRICE_BITS-1:0] price;
    logic [SIZE_BITS-1:0]  size;
    logic [ORD_BITS-1:0]   level_orders;
    logic [TS_BITS-1:0]    timestamp;
    logic                  starts_group;
    logic                  ends_group;

    modport source (
        output valid, kind, side, action, price, size, level_orders, timestamp,
               starts_group, ends_group,
        input  ready
    );

    modport sink (
        input  valid, kind, side, action, price, size, level_orders, timestamp,
               starts_group, ends_group,
        output ready
    );
endinterface

@@ rtl/core/plob_out_if.sv @@
// ----------------------------------------------------------------------------
// Order book result channel
// Valid/ready channel that carries one book summary per beat.
// ----------------------------------------------------------------------------
interface plob_out_if #(
    parameter int PRICE_BITS = plob_pkg::PRICE_BITS_DEF,
    parameter int SIZE_BITS  = plob_pkg::SIZE_BITS_DEF,
    parameter int CNT_BITS   = 6
);
    import plob_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  accepted;
    logic                  book_valid;
    logic [PRICE_BITS-1:0] best_bid_price;
    logic [SIZE_BITS-1:0]  best_bid_size;
    logic [ORD_BITS-1:0]   best_bid_orders;
    logic [PRICE_BITS-1:0] best_ask_price;
    logic [SIZE_BITS-1:0]  best_ask_size;
    logic [ORD_BITS-1:0]   best_ask_orders;
    logic [CNT_BITS-1:0]   bid_levels;
    logic [CNT_BITS-1:0]   ask_levels;
    logic [PRICE_BITS:0]   spread_ticks;

    modport source (
        output valid, accepted, book_valid, best_bid_price, best_bid_size,
               best_bid_orders, best_ask_price, best_ask_size, best_ask_orders,
               bid_levels, ask_levels, spread_ticks,
        input  ready
    );

    modport sink (
        input  valid, accepted, book_valid, best_bid_price, best_bid_size,
               best_bid_orders, best_ask_price, best_ask_size, best_ask_orders,
               bid_levels, ask_levels, spread_ticks,
        output ready
    );
endinterface

@@ rtl/core/plob_cell.sv @@
// ----------------------------------------------------------------------------
// Order book level cell
// Holds one price level and compares its price against the search key.
// ----------------------------------------------------------------------------
module plob_cell #(
    parameter int PRICE_BITS = plob_pkg::PRICE_BITS_DEF,
    parameter int SIZE_BITS  = plob_pkg::SIZE_BITS_DEF,
    parameter int IS_ASK     = 0
) (
    input  logic                          i_clk,
    input  plob_pkg::t_cell_op            i_op,
    input  logic [PRICE_BITS-1:0]         i_key,
    input  logic [SIZE_BITS-1:0]          i_size,
    input  logic [plob_pkg::ORD_BITS-1:0] i_orders,
    input  logic [PRICE_BITS-1:0]         i_prev_price,
    input  logic [SIZE_BITS-1:0]          i_prev_size,
    input  logic [plob_pkg::ORD_BITS-1:0] i_prev_orders,
    input  logic [PRICE_BITS-1:0]         i_next_price,
    input  logic [SIZE_BITS-1:0]          i_next_size,
    input  logic [plob_pkg::ORD_BITS-1:0] i_next_orders,
    output logic [PRICE_BITS-1:0]         o_price,
    output logic [SIZE_BITS-1:0]          o_size,
    output logic [plob_pkg::ORD_BITS-1:0] o_orders,
    output logic                          o_eq,
    output logic                          o_better
);
    import plob_pkg::*;

    logic [PRICE_BITS-1:0] r_price;
    logic [SIZE_BITS-1:0]  r_size;
    logic [ORD_BITS-1:0]   r_orders;

    always_ff @(posedge i_clk) begin
        case (i_op)
            C_LOAD: begin
                r_price  <= i_key;
                r_size   <= i_size;
                r_orders <= i_orders;
            end
            C_SIZE: begin
                r_size <= i_size;
            end
            C_SIZE_ORD: begin
                r_size   <= i_size;
                r_orders <= i_orders;
            end
            C_FROM_PREV: begin
                r_price  <= i_prev_price;
                r_size   <= i_prev_size;
                r_orders <= i_prev_orders;
            end
            C_FROM_NEXT: begin
                r_price  <= i_next_price;
                r_size   <= i_next_size;
                r_orders <= i_next_orders;
            end
            default: begin
            end
        endcase
    end

    assign o_price  = r_price;
    assign o_size   = r_size;
    assign o_orders = r_orders;
    assign o_eq     = (r_price == i_key);
    assign o_better = (IS_ASK != 0) ? (r_price < i_key) : (r_price > i_key);

endmodule

@@ rtl/core/plob_ladder.sv @@
// ----------------------------------------------------------------------------
// Order book ladder
// Row of level cells for one side; insert and erase shift between neighbors.
// ----------------------------------------------------------------------------
module plob_ladder #(
    parameter int LEVELS     = plob_pkg::LEVELS_DEF,
    parameter int PRICE_BITS = plob_pkg::PRICE_BITS_DEF,
    parameter int SIZE_BITS  = plob_pkg::SIZE_BITS_DEF,
    parameter int IS_ASK     = 0,
    parameter int CW         = $clog2(LEVELS + 1)
) (
    input  logic                          i_clk,
    input  plob_pkg::t_lad_cmd            i_cmd,
    input  logic [PRICE_BITS-1:0]         i_key,
    input  logic [SIZE_BITS-1:0]          i_size,
    input  logic [plob_pkg::ORD_BITS-1:0] i_orders,
    input  logic [CW-1:0]                 i_count,
    output logic [LEVELS-1:0]             o_match,
    output logic [LEVELS-1:0]             o_stop,
    output logic [SIZE_BITS-1:0]          o_sizes [LEVELS],
    output logic [PRICE_BITS-1:0]         o_top_price,
    output logic [SIZE_BITS-1:0]          o_top_size,
    output logic [plob_pkg::ORD_BITS-1:0] o_top_orders
);
    import plob_pkg::*;

    logic [PRICE_BITS-1:0] w_price  [LEVELS];
    logic [SIZE_BITS-1:0]  w_size   [LEVELS];
    logic [ORD_BITS-1:0]   w_orders [LEVELS];

    for (genvar g = 0; g < LEVELS; g++) begin : g_cell
        localparam logic [POS_BITS-1:0] IDX  = POS_BITS'(g);
        localparam bit                  LAST = (g == LEVELS - 1);

        t_cell_op              w_op;
        logic [PRICE_BITS-1:0] w_prev_price;
        logic [SIZE_BITS-1:0]  w_prev_size;
        logic [ORD_BITS-1:0]   w_prev_orders;
        logic [PRICE_BITS-1:0] w_next_price;
        logic [SIZE_BITS-1:0]  w_next_size;
        logic [ORD_BITS-1:0]   w_next_orders;
        logic                  w_eq;
        logic                  w_better;
        logic                  w_occ;

        if (g > 0) begin : g_prev
            assign w_prev_price  = w_price[g-1];
            assign w_prev_size   = w_size[g-1];
            assign w_prev_orders = w_orders[g-1];
        end else begin : g_first
            assign w_prev_price  = '0;
            assign w_prev_size   = '0;
            assign w_prev_orders = '0;
        end

        if (g < LEVELS - 1) begin : g_next
            assign w_next_price  = w_price[g+1];
            assign w_next_size   = w_size[g+1];
            assign w_next_orders = w_orders[g+1];
        end else begin : g_last
            assign w_next_price  = '0;
            assign w_next_size   = '0;
            assign w_next_orders = '0;
        end

        always_comb begin
            w_op = C_HOLD;
            unique case (i_cmd.op)
                LAD_INSERT: begin
                    if (IDX == i_cmd.pos) w_op = C_LOAD;
                    else if (IDX > i_cmd.pos) w_op = C_FROM_PREV;
                end
                LAD_ERASE: begin
                    if (IDX >= i_cmd.pos && !LAST) w_op = C_FROM_NEXT;
                end
                LAD_LOAD: begin
                    if (IDX == i_cmd.pos) w_op = C_LOAD;
                end
                LAD_SIZE: begin
                    if (IDX == i_cmd.pos) w_op = C_SIZE;
                end
                LAD_SIZE_ORD: begin
                    if (IDX == i_cmd.pos) w_op = C_SIZE_ORD;
                end
                default: begin
                end
            endcase
        end

        plob_cell #(
            .PRICE_BITS (PRICE_BITS),
            .SIZE_BITS  (SIZE_BITS),
            .IS_ASK     (IS_ASK)
        ) u_cell (
            .i_clk         (i_clk),
            .i_op          (w_op),
            .i_key         (i_key),
            .i_size        (i_size),
            .i_orders      (i_orders),
            .i_prev_price  (w_prev_price),
            .i_prev_size   (w_prev_size),
            .i_prev_orders (w_prev_orders),
            .i_next_price  (w_next_price),
            .i_next_size   (w_next_size),
            .i_next_orders (w_next_orders),
            .o_price       (w_price[g]),
            .o_size        (w_size[g]),
            .o_orders      (w_orders[g]),
            .o_eq          (w_eq),
            .o_better      (w_better)
        );

        assign w_occ      = (CW'(g) < i_count);
        assign o_match[g] = w_occ && w_eq;
        assign o_stop[g]  = !w_occ || !w_better;
        assign o_sizes[g] = w_size[g];
    end

    assign o_top_price  = w_price[0];
    assign o_top_size   = w_size[0];
    assign o_top_orders = w_orders[0];

endmodule

@@ rtl/core/price_level_order_book.sv @@
// ----------------------------------------------------------------------------
// Price level order book
// Sorted bid and ask ladders driven by level, order, snapshot and heartbeat
// messages, with one book summary per message.
// ----------------------------------------------------------------------------
// Each side is a row of LEVELS cells that compare against the message price in
// parallel and shift toward or away from the top. One message is handled at a
// time: it is taken in, searched, applied and summarized. A trade order walks
// the top of its side one level per cycle between the apply and summary steps,
// until the trade size or the side is used up. A new message is taken once the
// previous summary has been loaded into the output register; a stalled output
// holds the summary step.
module price_level_order_book #(
    parameter int LEVELS     = plob_pkg::LEVELS_DEF,
    parameter int PRICE_BITS = plob_pkg::PRICE_BITS_DEF,
    parameter int SIZE_BITS  = plob_pkg::SIZE_BITS_DEF,
    parameter int CW         = $clog2(LEVELS + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    plob_in_if.sink                           i_item,
    plob_out_if.source                        o_result,
    input  logic                              i_cfg_we,
    input  logic [plob_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [plob_pkg::THR_BITS-1:0]     i_cfg_data
);
    import plob_pkg::*;

    localparam int IW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int DW = (CW > DEPTH_BITS) ? CW : DEPTH_BITS;

    t_state                r_state, n_state;
    t_kind                 r_kind;
    logic                  r_side;
    t_action               r_action;
    logic [PRICE_BITS-1:0] r_price;
    logic [SIZE_BITS-1:0]  r_size;
    logic [ORD_BITS-1:0]   r_lo;
    logic [TS_BITS-1:0]    r_ts;
    logic                  r_starts;
    logic                  r_ends;

    logic [CW-1:0]         r_bid_cnt, n_bid_cnt, r_ask_cnt, n_ask_cnt;
    logic [CW-1:0]         r_snap_bid, n_snap_bid, r_snap_ask, n_snap_ask;
    logic                  r_valid, n_valid;
    logic [TS_BITS-1:0]    r_last, n_last;
    logic [DEPTH_BITS-1:0] r_depth;
    logic                  r_strict;
    logic [THR_BITS-1:0]   r_thr;

    logic                  r_found, n_found;
    logic [IW-1:0]         r_idx, n_idx;
    logic                  r_ins_ok, n_ins_ok;
    logic [IW-1:0]         r_ins_pos, n_ins_pos;
    logic [SIZE_BITS-1:0]  r_hit_size, n_hit_size;
    logic                  r_acc, n_acc;
    logic [SIZE_BITS-1:0]  r_left, n_left;

    logic                  r_out_valid;
    logic                  w_out_load;

    t_lad_cmd              w_cmd, w_bid_cmd, w_ask_cmd;
    logic [SIZE_BITS-1:0]  w_dsize;
    logic [ORD_BITS-1:0]   w_dord;

    logic [LEVELS-1:0]     w_bid_match, w_ask_match, w_bid_stop, w_ask_stop;
    logic [SIZE_BITS-1:0]  w_bid_sizes [LEVELS];
    logic [SIZE_BITS-1:0]  w_ask_sizes [LEVELS];
    logic [PRICE_BITS-1:0] w_bid_top_p, w_ask_top_p;
    logic [SIZE_BITS-1:0]  w_bid_top_s, w_ask_top_s;
    logic [ORD_BITS-1:0]   w_bid_top_o, w_ask_top_o;

    logic [LEVELS-1:0]     w_match, w_match_oh, w_stop, w_stop_oh;
    logic [CW-1:0]         w_cnt, w_eff;
    logic [DW-1:0]         w_dep_ext;
    logic [SIZE_BITS:0]    w_sum;
    logic [SIZE_BITS-1:0]  w_top_s;
    logic [TS_BITS-1:0]    w_gap;
    logic                  w_stale;
    logic [PRICE_BITS-1:0] w_bp, w_ap;
    logic [SIZE_BITS-1:0]  w_bs, w_as;
    logic [ORD_BITS-1:0]   w_bo, w_ao;
    logic                  w_depth_ok, w_eval, w_new_valid;

    plob_ladder #(
        .LEVELS (LEVELS), .PRICE_BITS (PRICE_BITS), .SIZE_BITS (SIZE_BITS),
        .IS_ASK (0), .CW (CW)
    ) u_bid (
        .i_clk        (i_clk),
        .i_cmd        (w_bid_cmd),
        .i_key        (r_price),
        .i_size       (w_dsize),
        .i_orders     (w_dord),
        .i_count      (r_bid_cnt),
        .o_match      (w_bid_match),
        .o_stop       (w_bid_stop),
        .o_sizes      (w_bid_sizes),
        .o_top_price  (w_bid_top_p),
        .o_top_size   (w_bid_top_s),
        .o_top_orders (w_bid_top_o)
    );

    plob_ladder #(
        .LEVELS (LEVELS), .PRICE_BITS (PRICE_BITS), .SIZE_BITS (SIZE_BITS),
        .IS_ASK (1), .CW (CW)
    ) u_ask (
        .i_clk        (i_clk),
        .i_cmd        (w_ask_cmd),
        .i_key        (r_price),
        .i_size       (w_dsize),
        .i_orders     (w_dord),
        .i_count      (r_ask_cnt),
        .o_match      (w_ask_match),
        .o_stop       (w_ask_stop),
        .o_sizes      (w_ask_sizes),
        .o_top_price  (w_ask_top_p),
        .o_top_size   (w_ask_top_s),
        .o_top_orders (w_ask_top_o)
    );

    assign w_bid_cmd = r_side ? t_lad_cmd'{LAD_IDLE, '0} : w_cmd;
    assign w_ask_cmd = r_side ? w_cmd : t_lad_cmd'{LAD_IDLE, '0};

    assign w_cnt      = r_side ? r_ask_cnt : r_bid_cnt;
    assign w_match    = r_side ? w_ask_match : w_bid_match;
    assign w_stop     = r_side ? w_ask_stop : w_bid_stop;
    assign w_match_oh = w_match & (~w_match + 1'b1);
    assign w_stop_oh  = w_stop & (~w_stop + 1'b1);
    assign w_top_s    = r_side ? w_ask_top_s : w_bid_top_s;
    assign w_sum      = {1'b0, r_hit_size} + {1'b0, r_size};

    assign w_dep_ext = DW'(r_depth);
    assign w_eff     = (r_depth == '0) ? CW'(1) :
                       (w_dep_ext > DW'(LEVELS)) ? CW'(LEVELS) : CW'(w_dep_ext);

    assign w_gap   = r_ts - r_last;
    assign w_stale = (r_ts > r_last) && (w_gap > TS_BITS'(r_thr));

    assign w_bp = (r_bid_cnt != '0) ? w_bid_top_p : '0;
    assign w_bs = (r_bid_cnt != '0) ? w_bid_top_s : '0;
    assign w_bo = (r_bid_cnt != '0) ? w_bid_top_o : '0;
    assign w_ap = (r_ask_cnt != '0) ? w_ask_top_p : '0;
    assign w_as = (r_ask_cnt != '0) ? w_ask_top_s : '0;
    assign w_ao = (r_ask_cnt != '0) ? w_ask_top_o : '0;

    assign w_depth_ok = (r_bid_cnt >= w_eff) && (r_ask_cnt >= w_eff);
    assign w_eval     = w_depth_ok && (!r_strict ||
                        (w_bp != '0 && w_ap != '0 && w_bs != '0 && w_as != '0 &&
                         w_bp < w_ap));

    always_comb begin
        w_new_valid = r_valid;
        case (r_kind)
            KIND_LEVEL, KIND_SNAP: begin
                if (r_ends) w_new_valid = w_eval;
            end
            KIND_ORDER: begin
                w_new_valid = r_acc && w_depth_ok;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_bid_cnt  = r_bid_cnt;
        n_ask_cnt  = r_ask_cnt;
        n_snap_bid = r_snap_bid;
        n_snap_ask = r_snap_ask;
        n_valid    = r_valid;
        n_last     = r_last;
        n_found    = r_found;
        n_idx      = r_idx;
        n_ins_ok   = r_ins_ok;
        n_ins_pos  = r_ins_pos;
        n_hit_size = r_hit_size;
        n_acc      = r_acc;
        n_left     = r_left;
        w_cmd      = '{LAD_IDLE, '0};
        w_dsize    = r_size;
        w_dord     = r_lo;
        w_out_load = 1'b0;
        i_item.ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                i_item.ready = i_rst_n;
                if (i_item.valid) n_state = S_LOOK;
            end
            S_LOOK: begin
                n_found    = |w_match;
                n_ins_ok   = |w_stop;
                n_idx      = '0;
                n_ins_pos  = '0;
                n_hit_size = '0;
                for (int k = 0; k < LEVELS; k++) begin
                    if (w_match_oh[k]) begin
                        n_idx      = n_idx | IW'(k);
                        n_hit_size = n_hit_size |
                                     (r_side ? w_ask_sizes[k] : w_bid_sizes[k]);
                    end
                    if (w_stop_oh[k]) n_ins_pos = n_ins_pos | IW'(k);
                end
                n_state = S_APPLY;
            end
            S_APPLY: begin
                n_state = S_EVAL;
                n_acc   = 1'b1;
                if (r_kind != KIND_HEARTBEAT) n_last = r_ts;
                case (r_kind)
                    KIND_LEVEL: begin
                        case (r_action)
                            ACT_CANCEL: begin
                                if (r_found) begin
                                    w_cmd = '{LAD_ERASE, POS_BITS'(r_idx)};
                                    if (r_side) n_ask_cnt = r_ask_cnt - 1'b1;
                                    else n_bid_cnt = r_bid_cnt - 1'b1;
                                end
                            end
                            ACT_MODIFY, ACT_ADD: begin
                                if (r_price != '0 && r_size != '0) begin
                                    if (r_found) begin
                                        w_cmd = '{LAD_SIZE_ORD, POS_BITS'(r_idx)};
                                    end else if (r_action == ACT_ADD && r_ins_ok) begin
                                        w_cmd = '{LAD_INSERT, POS_BITS'(r_ins_pos)};
                                        if (w_cnt != CW'(LEVELS)) begin
                                            if (r_side) n_ask_cnt = r_ask_cnt + 1'b1;
                                            else n_bid_cnt = r_bid_cnt + 1'b1;
                                        end
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    KIND_ORDER: begin
                        n_acc = 1'b0;
                        if (r_size != '0) begin
                            case (r_action)
                                ACT_ADD: begin
                                    if (r_price != '0) begin
                                        n_acc = 1'b1;
                                        if (r_found) begin
                                            w_dsize = w_sum[SIZE_BITS] ? '1 :
                                                      w_sum[SIZE_BITS-1:0];
                                            w_cmd = '{LAD_SIZE, POS_BITS'(r_idx)};
                                        end else if (r_ins_ok) begin
                                            w_dord = '0;
                                            w_cmd = '{LAD_INSERT, POS_BITS'(r_ins_pos)};
                                            if (w_cnt != CW'(LEVELS)) begin
                                                if (r_side) n_ask_cnt = r_ask_cnt + 1'b1;
                                                else n_bid_cnt = r_bid_cnt + 1'b1;
                                            end
                                        end
                                    end
                                end
                                ACT_CANCEL: begin
                                    if (r_price != '0 && r_found && r_hit_size >= r_size) begin
                                        n_acc = 1'b1;
                                        if (r_hit_size == r_size) begin
                                            w_cmd = '{LAD_ERASE, POS_BITS'(r_idx)};
                                            if (r_side) n_ask_cnt = r_ask_cnt - 1'b1;
                                            else n_bid_cnt = r_bid_cnt - 1'b1;
                                        end else begin
                                            w_dsize = r_hit_size - r_size;
                                            w_cmd = '{LAD_SIZE, POS_BITS'(r_idx)};
                                        end
                                    end
                                end
                                ACT_TRADE: begin
                                    n_acc   = 1'b1;
                                    n_left  = r_size;
                                    n_state = S_TRADE;
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                    KIND_SNAP: begin
                        logic [CW-1:0] v_pos;
                        logic [CW-1:0] v_cnt;
                        v_pos = r_starts ? '0 : (r_side ? r_snap_ask : r_snap_bid);
                        v_cnt = r_starts ? '0 : w_cnt;
                        if (r_starts) begin
                            n_bid_cnt  = '0;
                            n_ask_cnt  = '0;
                            n_snap_bid = '0;
                            n_snap_ask = '0;
                        end
                        if (v_pos < w_eff) begin
                            if (r_side) n_snap_ask = v_pos + 1'b1;
                            else n_snap_bid = v_pos + 1'b1;
                            if (r_price != '0 && r_size != '0 && v_cnt != CW'(LEVELS)) begin
                                w_cmd = '{LAD_LOAD, POS_BITS'(v_cnt)};
                                if (r_side) n_ask_cnt = v_cnt + 1'b1;
                                else n_bid_cnt = v_cnt + 1'b1;
                            end
                        end
                    end
                    default: begin
                        if (w_stale) n_valid = 1'b0;
                    end
                endcase
            end
            S_TRADE: begin
                if (r_left != '0 && w_cnt != '0) begin
                    if (r_left >= w_top_s) begin
                        w_cmd  = '{LAD_ERASE, '0};
                        n_left = r_left - w_top_s;
                        if (r_side) n_ask_cnt = r_ask_cnt - 1'b1;
                        else n_bid_cnt = r_bid_cnt - 1'b1;
                    end else begin
                        w_dsize = w_top_s - r_left;
                        w_cmd   = '{LAD_SIZE, '0};
                        n_left  = '0;
                    end
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!r_out_valid || o_result.ready) begin
                    w_out_load = 1'b1;
                    n_valid    = w_new_valid;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bid_cnt   <= '0;
            r_ask_cnt   <= '0;
            r_snap_bid  <= '0;
            r_snap_ask  <= '0;
            r_valid     <= 1'b0;
            r_last      <= '0;
            r_depth     <= DEPTH_RESET;
            r_strict    <= 1'b0;
            r_thr       <= STALE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_bid_cnt  <= n_bid_cnt;
            r_ask_cnt  <= n_ask_cnt;
            r_snap_bid <= n_snap_bid;
            r_snap_ask <= n_snap_ask;
            r_valid    <= n_valid;
            r_last     <= n_last;
            if (w_out_load) r_out_valid <= 1'b1;
            else if (o_result.ready) r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DEPTH:  r_depth  <= i_cfg_data[DEPTH_BITS-1:0];
                    CFG_STRICT: r_strict <= i_cfg_data[0];
                    CFG_STALE:  r_thr    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_kind   <= t_kind'(i_item.kind);
            r_side   <= i_item.side;
            r_action <= t_action'(i_item.action);
            r_price  <= i_item.price;
            r_size   <= i_item.size;
            r_lo     <= i_item.level_orders;
            r_ts     <= i_item.timestamp;
            r_starts <= i_item.starts_group;
            r_ends   <= i_item.ends_group;
        end
        r_found    <= n_found;
        r_idx      <= n_idx;
        r_ins_ok   <= n_ins_ok;
        r_ins_pos  <= n_ins_pos;
        r_hit_size <= n_hit_size;
        r_acc      <= n_acc;
        r_left     <= n_left;
        if (w_out_load) begin
            o_result.accepted        <= r_acc;
            o_result.book_valid      <= w_new_valid;
            o_result.best_bid_price  <= w_bp;
            o_result.best_bid_size   <= w_bs;
            o_result.best_bid_orders <= w_bo;
            o_result.best_ask_price  <= w_ap;
            o_result.best_ask_size   <= w_as;
            o_result.best_ask_orders <= w_ao;
            o_result.bid_levels      <= r_bid_cnt;
            o_result.ask_levels      <= r_ask_cnt;
            o_result.spread_ticks    <= {1'b0, w_ap} - {1'b0, w_bp};
        end
    end

    assign o_result.valid = r_out_valid;

    a_bid_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bid_cnt <= CW'(LEVELS))
        else $error("bid level count beyond ladder size");

    a_ask_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ask_cnt <= CW'(LEVELS))
        else $error("ask level count beyond ladder size");

    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> (r_state == S_LOOK))
        else $error("accepted beat did not start a search");

    a_result_from_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> ($past(r_state) == S_EVAL))
        else $error("result raised outside the summary step");

endmodule
